/* design/pdfq_pkg.sv */
// Shared types and codes for the priority drop flow queue.
package pdfq_pkg;

    typedef struct packed {
        logic [15:0] tag;
        logic [15:0] size;
        logic [31:0] pri;
        logic [15:0] flow;
    } entry_t;

    // Scan token handed from cell to cell
    typedef struct packed {
        logic   valid;
        logic   hit;
        entry_t ent;
    } token_t;

    typedef enum logic [1:0] {
        SCAN_MAX  = 2'd0,
        SCAN_MIN  = 2'd1,
        SCAN_FLOW = 2'd2
    } scan_mode_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic       append_en;
        logic       remove_en;
        scan_mode_t mode;
        logic [15:0] key_flow;
        entry_t     new_ent;
    } cell_ctrl_t;

    localparam logic [1:0] KIND_DEQUEUE = 2'd0;
    localparam logic [1:0] KIND_DROP    = 2'd1;
    localparam logic [1:0] KIND_EMPTY   = 2'd2;

    localparam logic       CMD_ENQUEUE = 1'b0;
    localparam logic [23:0] BYTES_MAX  = 24'hFFFFFF;
    localparam logic [23:0] LIMIT_RESET = 24'd36000;

endpackage

/* design/pdfq_cell.sv */
// One queue cell: holds an entry, shifts down on removal, relays the scan token.
module pdfq_cell
    import pdfq_pkg::*;
#(
    parameter int IDX_W      = 6,
    parameter int CELL_INDEX = 0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [IDX_W-1:0] rm_idx,
    input  logic             prev_valid,
    input  logic             nxt_valid,
    input  entry_t           nxt_ent,
    input  token_t           tok_in,
    input  logic [IDX_W-1:0] tok_idx_in,
    output logic             valid,
    output entry_t           ent,
    output token_t           tok_out,
    output logic [IDX_W-1:0] tok_idx_out
);

    logic             valid_reg;
    entry_t           ent_reg;
    token_t           tok_reg;
    logic [IDX_W-1:0] tok_idx_reg;
    logic             better;
    logic             at_or_after;

    assign at_or_after = IDX_W'(CELL_INDEX) >= rm_idx;

    always_comb
    begin
        case (ctrl.mode)
            SCAN_MAX:  better = !tok_in.hit || (ent_reg.pri >= tok_in.ent.pri);
            SCAN_MIN:  better = !tok_in.hit || (ent_reg.pri < tok_in.ent.pri);
            SCAN_FLOW: better = !tok_in.hit && (ent_reg.flow == ctrl.key_flow);
            default:   better = 1'b0;
        endcase
        better = better && valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            tok_reg   <= '0;
        end
        else
        begin
            if (ctrl.remove_en && at_or_after)
                valid_reg <= nxt_valid;
            else if (ctrl.append_en && !valid_reg && prev_valid)
                valid_reg <= 1'b1;

            if (tok_in.valid && better)
                tok_reg <= '{valid: 1'b1, hit: 1'b1, ent: ent_reg};
            else
                tok_reg <= tok_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.remove_en && at_or_after)
            ent_reg <= nxt_ent;
        else if (ctrl.append_en && !valid_reg && prev_valid)
            ent_reg <= ctrl.new_ent;

        if (tok_in.valid && better)
            tok_idx_reg <= IDX_W'(CELL_INDEX);
        else
            tok_idx_reg <= tok_idx_in;
    end

    assign valid       = valid_reg;
    assign ent         = ent_reg;
    assign tok_out     = tok_reg;
    assign tok_idx_out = tok_idx_reg;

endmodule

/* design/priority_drop_flow_queue.sv */
// Top level: cell chain plus sequencer, byte accounting and APB register.
//
//  channel   | handshake             | beat contents
//  ----------+-----------------------+---------------------------------------------
//  command   | start & !busy         | command, packet_tag/size/priority, flow_number
//  result    | result_valid (1 cyc)  | result_kind, out_tag/size/priority/flow
//  config    | psel&penable&pwrite   | byte_limit at paddr 0
//
// Entries sit in a row of cells in arrival order, cell 0 oldest. A search
// sends a token down the row, one cell per cycle. An enqueue that fits appends;
// one over byte_limit or depth scans for the highest priority and drops it or
// the newcomer; a dropped stored entry leaves before the newcomer is appended.
// A dequeue scans for the lowest priority, then the oldest entry of its flow.
// Reset clears all valid bits, counts and byte_limit to 36000; no clearing pass.
// Results cannot be held off; busy falls with the beat unless an append follows.
module priority_drop_flow_queue
    import pdfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [15:0] packet_tag,
    input  logic [15:0] packet_size,
    input  logic [31:0] packet_priority,
    input  logic [15:0] flow_number,
    output logic        result_valid,
    output logic [1:0]  result_kind,
    output logic [15:0] out_tag,
    output logic [15:0] out_size,
    output logic [31:0] out_priority,
    output logic [15:0] out_flow,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DECIDE = 5'b00010,
        ST_SCAN1  = 5'b00100,
        ST_SCAN2  = 5'b01000,
        ST_APPEND = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    logic             cmd_reg;
    entry_t           in_reg;
    logic [23:0]      limit_reg;
    logic [23:0]      bytes_reg, bytes_next;
    logic [CNT_W-1:0] count_reg, count_next;
    scan_mode_t       mode_reg, mode_next;
    logic [15:0]      key_reg, key_next;
    logic [IDX_W-1:0] rm_idx;

    logic             res_valid_reg, res_valid_next;
    logic [1:0]       res_kind_reg, res_kind_next;
    entry_t           res_ent_reg, res_ent_next;

    cell_ctrl_t       ctrl;
    token_t           inject;

    logic             cell_valid [QUEUE_DEPTH];
    entry_t           cell_ent   [QUEUE_DEPTH];
    token_t           cell_tok   [QUEUE_DEPTH];
    logic [IDX_W-1:0] cell_idx   [QUEUE_DEPTH];

    logic [24:0]      sum;
    logic [23:0]      total;
    logic             full;
    token_t           tok_last;
    logic [IDX_W-1:0] idx_last;
    logic             accept;

    // Config register
    assign pready = 1'b1;
    assign prdata = (paddr == 3'd0) ? {8'd0, limit_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (psel && penable && pwrite && pready && paddr == 3'd0)
            limit_reg <= pwdata[23:0];
    end

    // Cell chain
    generate
        for (genvar i = 0; i < QUEUE_DEPTH; i++)
        begin : g_cell
            logic   pv, nv;
            entry_t ne;
            token_t ti;
            logic [IDX_W-1:0] ii;
            if (i == 0)
            begin : g_first
                assign pv = 1'b1;
                assign ti = inject;
                assign ii = '0;
            end
            else
            begin : g_mid
                assign pv = cell_valid[i-1];
                assign ti = cell_tok[i-1];
                assign ii = cell_idx[i-1];
            end
            if (i == QUEUE_DEPTH - 1)
            begin : g_last
                assign nv = 1'b0;
                assign ne = cell_ent[i];
            end
            else
            begin : g_inner
                assign nv = cell_valid[i+1];
                assign ne = cell_ent[i+1];
            end
            pdfq_cell #(
                .IDX_W      (IDX_W),
                .CELL_INDEX (i)
            ) u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctrl        (ctrl),
                .rm_idx      (rm_idx),
                .prev_valid  (pv),
                .nxt_valid   (nv),
                .nxt_ent     (ne),
                .tok_in      (ti),
                .tok_idx_in  (ii),
                .valid       (cell_valid[i]),
                .ent         (cell_ent[i]),
                .tok_out     (cell_tok[i]),
                .tok_idx_out (cell_idx[i])
            );
        end
    endgenerate

    assign tok_last = cell_tok[QUEUE_DEPTH-1];
    assign idx_last = cell_idx[QUEUE_DEPTH-1];
    assign rm_idx   = idx_last;

    // Byte total after adding the new packet, saturating
    assign sum   = {1'b0, bytes_reg} + {9'd0, in_reg.size};
    assign total = sum[24] ? BYTES_MAX : sum[23:0];
    assign full  = count_reg == CNT_W'(QUEUE_DEPTH);

    assign busy   = state_reg != ST_IDLE;
    assign accept = start && !busy;

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        bytes_next     = bytes_reg;
        count_next     = count_reg;
        mode_next      = mode_reg;
        key_next       = key_reg;
        res_valid_next = 1'b0;
        res_kind_next  = res_kind_reg;
        res_ent_next   = res_ent_reg;
        inject         = '0;
        ctrl.append_en = 1'b0;
        ctrl.remove_en = 1'b0;
        ctrl.new_ent   = in_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                    state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (cmd_reg == CMD_ENQUEUE)
                begin
                    if (!(total > limit_reg) && !full)
                    begin
                        ctrl.append_en = 1'b1;
                        bytes_next     = total;
                        count_next     = count_reg + 1'b1;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        mode_next    = SCAN_MAX;
                        inject.valid = 1'b1;
                        state_next   = ST_SCAN1;
                    end
                end
                else if (count_reg == '0)
                begin
                    res_valid_next = 1'b1;
                    res_kind_next  = KIND_EMPTY;
                    res_ent_next   = '0;
                    state_next     = ST_IDLE;
                end
                else
                begin
                    mode_next    = SCAN_MIN;
                    inject.valid = 1'b1;
                    state_next   = ST_SCAN1;
                end
            end
            ST_SCAN1:
            begin
                if (tok_last.valid)
                begin
                    if (cmd_reg == CMD_ENQUEUE)
                    begin
                        res_valid_next = 1'b1;
                        res_kind_next  = KIND_DROP;
                        if (!tok_last.hit || in_reg.pri >= tok_last.ent.pri)
                        begin
                            res_ent_next = in_reg;
                            state_next   = ST_IDLE;
                        end
                        else
                        begin
                            res_ent_next   = tok_last.ent;
                            bytes_next     = (total > {8'd0, tok_last.ent.size}) ?
                                             total - {8'd0, tok_last.ent.size} : '0;
                            ctrl.remove_en = 1'b1;
                            state_next     = ST_APPEND;
                        end
                    end
                    else
                    begin
                        mode_next    = SCAN_FLOW;
                        key_next     = tok_last.ent.flow;
                        inject.valid = 1'b1;
                        state_next   = ST_SCAN2;
                    end
                end
            end
            ST_SCAN2:
            begin
                if (tok_last.valid)
                begin
                    res_valid_next = 1'b1;
                    res_kind_next  = KIND_DEQUEUE;
                    res_ent_next   = tok_last.ent;
                    bytes_next     = (bytes_reg > {8'd0, tok_last.ent.size}) ?
                                     bytes_reg - {8'd0, tok_last.ent.size} : '0;
                    count_next     = count_reg - 1'b1;
                    ctrl.remove_en = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_APPEND:
            begin
                // removal done last cycle, slot count unchanged overall
                ctrl.append_en = 1'b1;
                state_next     = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a token injected this cycle is judged by the mode and key it starts with
        ctrl.mode     = mode_next;
        ctrl.key_flow = key_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bytes_reg     <= '0;
            count_reg     <= '0;
            mode_reg      <= SCAN_MAX;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bytes_reg     <= bytes_next;
            count_reg     <= count_next;
            mode_reg      <= mode_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            in_reg  <= '{tag: packet_tag, size: packet_size,
                         pri: packet_priority, flow: flow_number};
        end
        key_reg      <= key_next;
        res_kind_reg <= res_kind_next;
        res_ent_reg  <= res_ent_next;
    end

    assign result_valid = res_valid_reg;
    assign result_kind  = res_kind_reg;
    assign out_tag      = res_ent_reg.tag;
    assign out_size     = res_ent_reg.size;
    assign out_priority = res_ent_reg.pri;
    assign out_flow     = res_ent_reg.flow;

endmodule

/* tb/pdfq_checker.sv */
// Checker: predicts queue results from accepted commands and compares output beats.
`timescale 1ns / 1ps
module pdfq_checker
    import pdfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic        command,
    input  logic [15:0] packet_tag,
    input  logic [15:0] packet_size,
    input  logic [31:0] packet_priority,
    input  logic [15:0] flow_number,
    input  logic        result_valid,
    input  logic [1:0]  result_kind,
    input  logic [15:0] out_tag,
    input  logic [15:0] out_size,
    input  logic [31:0] out_priority,
    input  logic [15:0] out_flow,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output int          fail_count,
    output int          pending,
    output int          result_count
);

    typedef struct packed {
        logic [1:0] kind;
        entry_t     ent;
    } report_t;

    entry_t      held[$];
    report_t     expected_reports[$];
    logic [23:0] limit_shadow;
    logic [23:0] byte_total;

    assign pending = expected_reports.size();

    // Apply one command to the shadow queue and queue the report it causes.
    task automatic apply_command(input logic cmd, input entry_t pkt);
        logic [24:0] sum;
        logic [23:0] total;
        int          worst;
        int          best;
        int          pick;
        report_t     rep;
        if (cmd == CMD_ENQUEUE) begin
            sum   = byte_total + pkt.size;
            total = (sum > BYTES_MAX) ? BYTES_MAX : sum[23:0];
            if (total <= limit_shadow && held.size() < QUEUE_DEPTH) begin
                held = {held, pkt};
                byte_total = total;
                return;
            end
            worst = -1;
            foreach (held[i])
                if (worst < 0 || held[i].pri >= held[worst].pri)
                    worst = i;
            rep.kind = KIND_DROP;
            if (worst < 0 || pkt.pri >= held[worst].pri) begin
                // newcomer is the worst: queue untouched
                rep.ent = pkt;
            end
            else begin
                rep.ent    = held[worst];
                byte_total = (total > held[worst].size) ? total - held[worst].size : '0;
                held.delete(worst);
                held = {held, pkt};
            end
            expected_reports = {expected_reports, rep};
        end
        else if (held.size() == 0) begin
            rep.kind = KIND_EMPTY;
            rep.ent  = '0;
            expected_reports = {expected_reports, rep};
        end
        else begin
            best = 0;
            foreach (held[i])
                if (held[i].pri < held[best].pri)
                    best = i;
            pick = best;
            foreach (held[i])
                if (held[i].flow == held[best].flow) begin
                    pick = i;
                    break;
                end
            rep.kind   = KIND_DEQUEUE;
            rep.ent    = held[pick];
            byte_total = (byte_total > held[pick].size) ? byte_total - held[pick].size : '0;
            held.delete(pick);
            expected_reports = {expected_reports, rep};
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        report_t want;
        entry_t  pkt;
        if (!rst_n) begin
            held.delete();
            expected_reports.delete();
            limit_shadow <= LIMIT_RESET;
            byte_total   = '0;
            fail_count   <= 0;
            result_count <= 0;
        end
        else begin
            // results first: a beat leaving now belongs to an earlier command
            if (result_valid) begin
                result_count <= result_count + 1;
                if (expected_reports.size() == 0) begin
                    $error("unexpected result beat kind=%0d tag=%0h", result_kind, out_tag);
                    fail_count <= fail_count + 1;
                end
                else begin
                    want = expected_reports.pop_front();
                    if (result_kind !== want.kind || out_tag !== want.ent.tag ||
                        out_size !== want.ent.size || out_priority !== want.ent.pri ||
                        out_flow !== want.ent.flow)
                        fail_count <= fail_count + 1;
                    if (result_kind !== want.kind)
                        $error("result_kind exp %0d got %0d", want.kind, result_kind);
                    if (out_tag !== want.ent.tag)
                        $error("out_tag exp %0h got %0h", want.ent.tag, out_tag);
                    if (out_size !== want.ent.size)
                        $error("out_size exp %0d got %0d", want.ent.size, out_size);
                    if (out_priority !== want.ent.pri)
                        $error("out_priority exp %0h got %0h", want.ent.pri, out_priority);
                    if (out_flow !== want.ent.flow)
                        $error("out_flow exp %0h got %0h", want.ent.flow, out_flow);
                end
            end
            if (start && !busy) begin
                pkt = '{tag: packet_tag, size: packet_size, pri: packet_priority,
                        flow: flow_number};
                apply_command(command, pkt);
            end
            if (psel && penable && pwrite && paddr == 3'd0)
                limit_shadow <= pwdata[23:0];
        end
    end

endmodule

/* tb/testbench.sv */
// Top of the queue testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module testbench;
    import pdfq_pkg::*;

    localparam int DEPTH = 64;
    // Slowest command is a dequeue, which makes two scans of the row; padded for end drain.
    localparam int DRAIN_CYCLES = 4 * DEPTH + 20;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        command;
    logic [15:0] packet_tag;
    logic [15:0] packet_size;
    logic [31:0] packet_priority;
    logic [15:0] flow_number;
    logic        result_valid;
    logic [1:0]  result_kind;
    logic [15:0] out_tag;
    logic [15:0] out_size;
    logic [31:0] out_priority;
    logic [15:0] out_flow;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          result_count;
    int          commands_sent;

    priority_drop_flow_queue #(.QUEUE_DEPTH(DEPTH)) DUT (.*);

    pdfq_checker #(.QUEUE_DEPTH(DEPTH)) checker_inst (
        .clk, .rst_n, .start, .busy, .command, .packet_tag, .packet_size,
        .packet_priority, .flow_number, .result_valid, .result_kind, .out_tag,
        .out_size, .out_priority, .out_flow, .psel, .penable, .pwrite, .paddr,
        .pwdata, .fail_count, .pending, .result_count
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Hand one command beat to the block; start stays up until it is taken.
    task automatic send_beat(input logic cmd, input logic [15:0] tag,
                             input logic [15:0] size, input logic [31:0] pri,
                             input logic [15:0] flow);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 9);
        repeat (gap) @(posedge clk);
        start           <= 1'b1;
        command         <= cmd;
        packet_tag      <= tag;
        packet_size     <= size;
        packet_priority <= pri;
        flow_number     <= flow;
        do @(posedge clk); while (busy);
        start <= 1'b0;
        commands_sent++;
        // block is busy in the cycle after an accept anyway
        @(posedge clk);
    endtask

    // Let the block settle, then write byte_limit through the APB port.
    task automatic write_limit(input logic [23:0] value);
        while (pending != 0 || busy) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        paddr   <= 3'd0;
        pwdata  <= {8'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly a few flows with small priorities so that dequeues follow flows.
    task automatic random_phase(input int count, input int deq_pct, input int max_size);
        logic [31:0] pri;
        repeat (count) begin
            case ($urandom_range(0, 9))
                0:       pri = $urandom();
                1:       pri = 32'hFFFF_FFFF;
                default: pri = $urandom_range(0, 15);
            endcase
            send_beat($urandom_range(0, 99) < deq_pct, 16'($urandom()),
                      ($urandom_range(0, 19) == 0) ? 16'($urandom()) :
                                                     16'($urandom_range(0, max_size)),
                      pri,
                      ($urandom_range(0, 9) == 0) ? 16'($urandom()) :
                                                    16'($urandom_range(0, 7)));
        end
    endtask

    initial
    begin
        rst_n   = 1'b0;
        start   = 1'b0;
        command = CMD_ENQUEUE;
        packet_tag      = '0;
        packet_size     = '0;
        packet_priority = '0;
        flow_number     = '0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        commands_sent = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty dequeue, zero-size packet, extremes of every field.
        send_beat(1'b1, 16'h0, 16'h0, 32'h0, 16'h0);
        send_beat(CMD_ENQUEUE, 16'h0000, 16'd0, 32'h0, 16'h0000);
        send_beat(CMD_ENQUEUE, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
        send_beat(CMD_ENQUEUE, 16'h1234, 16'd100, 32'hFFFF_FFFF, 16'h0001);
        // byte limit overflow: newcomer worst, then an older entry worst
        send_beat(CMD_ENQUEUE, 16'hAAAA, 16'hFFFF, 32'hFFFF_FFFF, 16'h0002);
        send_beat(CMD_ENQUEUE, 16'h5555, 16'd40000, 32'd3, 16'h0003);
        send_beat(1'b1, 16'h0, 16'h0, 32'h0, 16'h0);
        send_beat(1'b1, 16'h0, 16'h0, 32'h0, 16'h0);
        send_beat(1'b1, 16'h0, 16'h0, 32'h0, 16'h0);
        send_beat(1'b1, 16'h0, 16'h0, 32'h0, 16'h0);
        send_beat(1'b1, 16'h0, 16'h0, 32'h0, 16'h0);

        // Limit at maximum: store fills to depth and drops.
        write_limit(24'hFFFFFF);
        for (int i = 0; i < DEPTH + 4; i++)
            send_beat(CMD_ENQUEUE, 16'(i), 16'hFFFF,
                      (i % 3 == 0) ? 32'hFFFF_FFFF : 32'(i), 16'(i % 5));
        random_phase(350, 45, 65535);

        // Limit zero: every enqueue drops (nonzero size).
        write_limit(24'd0);
        random_phase(150, 30, 2000);

        write_limit(24'd5000);
        random_phase(500, 40, 1500);

        write_limit(24'd36000);
        random_phase(500, 35, 1500);

        // Drain what remains so dequeues reach the empty case again.
        repeat (DEPTH + 2) send_beat(1'b1, 16'h0, 16'h0, 32'h0, 16'h0);

        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Covered %0d commands and %0d result beats over four byte limits.",
                 commands_sent, result_count);
        if (fail_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // Worst case about 1700 items, each at most a dequeue with two scans, at 4 ns a clock; several times over.
    initial
    begin
        #10ms;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
